[rtl/srtp_pkg.sv]
// shared types, constants and lookup functions of the signed radix-to-text unit
package srtp_pkg;

  // field widths
  localparam int VALUE_W = 64;
  localparam int BASE_W  = 5;
  localparam int PREC_W  = 6;
  localparam int CHAR_W  = 7;
  localparam int STAT_W  = 2;
  localparam int DIGIT_W = 4;

  // stream word widths, fields packed from bit 0 and padded to whole bytes
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 8;

  // digit store and counters
  localparam int DEPTH    = VALUE_W;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int COUNT_W  = ADDR_W + 1;
  localparam int BIT_CNT_W = $clog2(VALUE_W);

  // status codes
  localparam logic [STAT_W-1:0] STAT_CHAR     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_BASE = 2'd2;

  // radix limits
  localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;
  localparam logic [BASE_W-1:0] BASE_DEC = 5'd10;

  // characters
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

  // most negative value and its fixed decimal text
  localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam int MIN_TEXT_LEN = 20;
  localparam int TXT_IDX_W = $clog2(MIN_TEXT_LEN);
  localparam logic [TXT_IDX_W-1:0] TXT_LAST = TXT_IDX_W'(MIN_TEXT_LEN - 1);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // what the emit phase sends
  typedef enum logic [1:0] {
    MODE_STATUS,
    MODE_MIN_TEXT,
    MODE_DIGITS
  } mode_t;

  // digit value to lower-case character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_ALPHA + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

  // text of the most negative value, one character per index
  function automatic logic [CHAR_W-1:0] min_text(input logic [TXT_IDX_W-1:0] i);
    logic [CHAR_W-1:0] c;
    unique case (i)
      5'd0:    c = CHAR_MINUS;
      5'd1:    c = 7'h39;
      5'd2:    c = 7'h32;
      5'd3:    c = 7'h32;
      5'd4:    c = 7'h33;
      5'd5:    c = 7'h33;
      5'd6:    c = 7'h37;
      5'd7:    c = 7'h32;
      5'd8:    c = 7'h30;
      5'd9:    c = 7'h33;
      5'd10:   c = 7'h36;
      5'd11:   c = 7'h38;
      5'd12:   c = 7'h35;
      5'd13:   c = 7'h34;
      5'd14:   c = 7'h37;
      5'd15:   c = 7'h37;
      5'd16:   c = 7'h35;
      5'd17:   c = 7'h38;
      5'd18:   c = 7'h30;
      5'd19:   c = 7'h38;
      default: c = CHAR_NONE;
    endcase
    return c;
  endfunction

endpackage

[rtl/signed_radix_to_text_precision_unit.sv]
// signed radix-to-text converter: top level with bit-serial divider and digit store
//
// Converts one signed 64-bit value to text in base 2 to 16 (digits 0-9, a-f),
// most significant character first, one character per output word, tlast on
// the final one. Digits are left-padded with '0' up to the requested precision
// (clamped to MAX_PRECISION); negative values get a leading '-' in base 10 only
// and their magnitude's digits in other bases. The most negative value gives
// its decimal text in every valid base. An invalid base gives one word with
// status 2, zero at precision zero one word with status 1. The input is taken
// only while the unit is idle. Each digit is one pass of the shared one-bit
// restoring divide step over the 64-bit dividend (compare and subtract of a
// 5-bit trial remainder against the base); the largest magnitude has 63
// binary digits. Emission waits for the registered read of the digit store
// before each digit and can be held by a downstream stall.
module signed_radix_to_text_precision_unit #(
  parameter int MAX_PRECISION = 63
) (
  input  logic                              clk,
  input  logic                              rst,
  // fields from bit 0: value[63:0], base[68:64], precision[74:69], zero pad
  input  logic [srtp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // fields from bit 0: char_code[6:0], zero pad
  output logic [srtp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // fields from bit 0: status[1:0]
  output logic [srtp_pkg::STAT_W-1:0]       m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);
  import srtp_pkg::*;

  localparam logic [PREC_W-1:0] MaxPrec = PREC_W'(MAX_PRECISION);

  // input unpacking
  logic [VALUE_W-1:0] in_value;
  logic [BASE_W-1:0]  in_base;
  logic [PREC_W-1:0]  in_prec;
  logic [PREC_W-1:0]  prec_clamped;
  logic               in_neg;
  logic               base_bad;

  assign in_value = s_axis_tdata[VALUE_W-1:0];
  assign in_base  = s_axis_tdata[VALUE_W +: BASE_W];
  assign in_prec  = s_axis_tdata[VALUE_W+BASE_W +: PREC_W];
  assign prec_clamped = (in_prec > MaxPrec) ? MaxPrec : in_prec;
  assign in_neg   = in_value[VALUE_W-1];
  assign base_bad = (in_base < BASE_MIN) || (in_base > BASE_MAX);

  // sequencer and working registers
  state_t               state;
  mode_t                mode;
  logic [STAT_W-1:0]    stat_code;
  logic [VALUE_W-1:0]   mag;
  logic [BASE_W-1:0]    base_r;
  logic [DIGIT_W-1:0]   rem;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [COUNT_W-1:0]   nd;
  logic [PREC_W-1:0]    prec_r;
  logic [PREC_W-1:0]    pads;
  logic                 sign_pend;
  logic [TXT_IDX_W-1:0] txt_idx;
  logic [DIGIT_W-1:0]   rd_data;
  logic                 rd_ok;

  // digit store, least significant digit at address 0
  logic [DIGIT_W-1:0]   digit_mem [DEPTH];
  logic [ADDR_W-1:0]    rd_addr;

  assign s_axis_tready = (state == ST_IDLE);

  // shared divide step: shift one dividend bit into the partial remainder
  logic [BASE_W-1:0]  trial;
  logic               fits;
  logic [DIGIT_W-1:0] rem_next;
  logic [VALUE_W-1:0] quo_next;
  logic [COUNT_W-1:0] nd_inc;
  logic               div_done;

  assign trial    = {rem, mag[VALUE_W-1]};
  assign fits     = (trial >= base_r);
  assign rem_next = fits ? DIGIT_W'(trial - base_r) : DIGIT_W'(trial);
  assign quo_next = {mag[VALUE_W-2:0], fits};
  assign nd_inc   = nd + COUNT_W'(1);
  assign div_done = (bit_cnt == BIT_CNT_W'(VALUE_W - 1));

  // emit decision
  logic              out_free;
  logic              emit_go;
  logic              emit_last;
  logic [CHAR_W-1:0] emit_char;
  logic [STAT_W-1:0] emit_stat;
  logic              digit_pop;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign rd_addr  = nd[ADDR_W-1:0] - ADDR_W'(1);

  always_comb begin
    emit_go   = 1'b0;
    emit_last = 1'b0;
    emit_char = CHAR_NONE;
    emit_stat = STAT_CHAR;
    digit_pop = 1'b0;
    if ((state == ST_EMIT) && out_free) begin
      unique case (mode)
        MODE_STATUS: begin
          emit_go   = 1'b1;
          emit_last = 1'b1;
          emit_stat = stat_code;
        end
        MODE_MIN_TEXT: begin
          emit_go   = 1'b1;
          emit_char = min_text(txt_idx);
          emit_last = (txt_idx == TXT_LAST);
        end
        MODE_DIGITS: begin
          priority if (sign_pend) begin
            emit_go   = 1'b1;
            emit_char = CHAR_MINUS;
          end else if (pads != '0) begin
            emit_go   = 1'b1;
            emit_char = CHAR_ZERO;
            emit_last = (pads == PREC_W'(1)) && (nd == '0);
          end else if (rd_ok) begin
            emit_go   = 1'b1;
            emit_char = digit_char(rd_data);
            emit_last = (nd == COUNT_W'(1));
            digit_pop = 1'b1;
          end
        end
        default: begin
          emit_go = 1'b0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      rd_ok         <= 1'b0;
    end else begin
      // a new word loads, otherwise a taken word leaves
      m_axis_tvalid <= emit_go || (m_axis_tvalid && !m_axis_tready);
      // read data matches the current digit in the cycle after the address settles
      rd_ok <= (state == ST_EMIT) && !digit_pop;

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            prec_r    <= prec_clamped;
            base_r    <= in_base;
            mag       <= in_neg ? (~in_value + VALUE_W'(1)) : in_value;
            sign_pend <= in_neg && (in_base == BASE_DEC);
            rem       <= '0;
            bit_cnt   <= '0;
            nd        <= '0;
            txt_idx   <= '0;
            pads      <= prec_clamped;
            priority if (base_bad) begin
              mode      <= MODE_STATUS;
              stat_code <= STAT_BAD_BASE;
              state     <= ST_EMIT;
            end else if (in_value == MOST_NEG) begin
              mode  <= MODE_MIN_TEXT;
              state <= ST_EMIT;
            end else if ((in_value == '0) && (prec_clamped == '0)) begin
              mode      <= MODE_STATUS;
              stat_code <= STAT_EMPTY;
              state     <= ST_EMIT;
            end else if (in_value == '0) begin
              mode  <= MODE_DIGITS;
              state <= ST_EMIT;
            end else begin
              mode  <= MODE_DIGITS;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          bit_cnt <= bit_cnt + BIT_CNT_W'(1);
          if (div_done) begin
            // one digit finished: store it, restart on the quotient
            mag <= quo_next;
            rem <= '0;
            nd  <= nd_inc;
            if (quo_next == '0) begin
              pads  <= ({1'b0, prec_r} > nd_inc) ?
                       PREC_W'({1'b0, prec_r} - nd_inc) : '0;
              state <= ST_EMIT;
            end
          end else begin
            mag <= quo_next;
            rem <= rem_next;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (mode == MODE_MIN_TEXT) begin
              txt_idx <= txt_idx + TXT_IDX_W'(1);
            end
            if (sign_pend) begin
              sign_pend <= 1'b0;
            end else if (pads != '0) begin
              pads <= pads - PREC_W'(1);
            end else if (digit_pop) begin
              nd <= nd - COUNT_W'(1);
            end
            if (emit_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_axis_tdata <= {{(OUT_DATA_W-CHAR_W){1'b0}}, emit_char};
      m_axis_tuser <= emit_stat;
      m_axis_tlast <= emit_last;
    end
  end

  // digit store write at the end of each divide pass
  always_ff @(posedge clk) begin
    if ((state == ST_DIV) && div_done) begin
      digit_mem[nd[ADDR_W-1:0]] <= rem_next;
    end
  end

  // digit store registered read
  always_ff @(posedge clk) begin
    rd_data <= digit_mem[rd_addr];
  end

endmodule
